@@ rtl/mmlas_pkg.sv @@
`timescale 1ns / 1ps
package mmlas_pkg;

	localparam int DEF_MAX_TEACHERS = 16;
	localparam int DEF_MAX_COURSES  = 32;

	localparam int OP_W      = 2;
	localparam int TIDX_W    = 4;
	localparam int CIDX_W    = 5;
	localparam int NT_W      = 5;
	localparam int NC_W      = 6;
	localparam int LOAD_W    = 6;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 8;
	localparam int ADDR_W    = 3;

	typedef enum logic [OP_W-1:0] {
		OP_SET_TEACH    = 2'd0,
		OP_SET_CONFLICT = 2'd1,
		OP_SOLVE        = 2'd2,
		OP_UNUSED       = 2'd3
	} op_t;

	typedef enum logic [ADDR_W-1:0] {
		REG_NUM_TEACHERS = 3'd0,
		REG_NUM_COURSES  = 3'd4
	} reg_addr_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_teach;
		logic load_conflict;
		logic init;
		logic take_deeper;
		logic skip_teacher;
		logic back;
		logic sweep_clr;
		logic sweep_step;
		logic sweep_commit;
		logic emit;
	} mmlas_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic level_full;
		logic teachers_done;
		logic may_take;
		logic fits;
		logic level_zero;
		logic sweep_done;
		logic out_free;
	} mmlas_stat_t;

	// Index width for an array of n entries, never below one bit.
	function automatic int idx_w(input int n);
		return (n <= 1) ? 1 : $clog2(n);
	endfunction

endpackage

@@ rtl/mmlas_ctrl.sv @@
`timescale 1ns / 1ps
module mmlas_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [1:0]             in_op,
	output logic                   in_ready,
	input  mmlas_pkg::mmlas_stat_t stat,
	output mmlas_pkg::mmlas_cmd_t  cmd
);
	import mmlas_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRY,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	state_t state_q;
	op_t    op;
	logic   accept;

	assign op       = op_t'(in_op);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_teach    = (op == OP_SET_TEACH);
					cmd.load_conflict = (op == OP_SET_CONFLICT);
					cmd.init          = (op == OP_SOLVE);
				end
			end
			ST_TRY: begin
				if (stat.level_full) begin
					cmd.sweep_clr = 1'b1;
				end else if (stat.teachers_done) begin
					cmd.back = !stat.level_zero;
				end else if (stat.may_take && stat.fits) begin
					cmd.take_deeper = 1'b1;
				end else begin
					cmd.skip_teacher = 1'b1;
				end
			end
			ST_SWEEP: begin
				if (stat.sweep_done) begin
					cmd.sweep_commit = 1'b1;
					cmd.back         = !stat.level_zero;
				end else begin
					cmd.sweep_step = 1'b1;
				end
			end
			ST_FINISH: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && op == OP_SOLVE) state_q <= ST_TRY;
				end
				ST_TRY: begin
					if (stat.level_full) begin
						state_q <= ST_SWEEP;
					end else if (stat.teachers_done && stat.level_zero) begin
						state_q <= ST_FINISH;
					end
				end
				ST_SWEEP: begin
					if (stat.sweep_done) begin
						state_q <= stat.level_zero ? ST_FINISH : ST_TRY;
					end
				end
				ST_FINISH: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/mmlas_dp.sv @@
`timescale 1ns / 1ps
module mmlas_dp #(
	parameter int MAX_TEACHERS = mmlas_pkg::DEF_MAX_TEACHERS,
	parameter int MAX_COURSES  = mmlas_pkg::DEF_MAX_COURSES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mmlas_pkg::mmlas_cmd_t        cmd,
	output mmlas_pkg::mmlas_stat_t       stat,
	input  logic [mmlas_pkg::TIDX_W-1:0] teacher_index,
	input  logic [mmlas_pkg::CIDX_W-1:0] course_index,
	input  logic [mmlas_pkg::CIDX_W-1:0] other_course,
	input  logic [mmlas_pkg::NT_W-1:0]   num_teachers,
	input  logic [mmlas_pkg::NC_W-1:0]   num_courses,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [mmlas_pkg::LOAD_W-1:0] best_max_load
);
	import mmlas_pkg::*;

	localparam int TW   = idx_w(MAX_TEACHERS);
	localparam int TW1  = $clog2(MAX_TEACHERS + 1);
	localparam int CW   = idx_w(MAX_COURSES);
	localparam int KW1  = $clog2(MAX_COURSES + 1);
	localparam int BW   = $clog2(MAX_COURSES + 2);
	localparam int XW   = 8;
	localparam int TIW  = (TW > TIDX_W) ? TW : TIDX_W;
	localparam int CIW  = (CW > CIDX_W) ? CW : CIDX_W;

	logic [MAX_COURSES-1:0] teach_rows_q    [MAX_TEACHERS];
	logic [MAX_COURSES-1:0] conflict_rows_q [MAX_COURSES];
	logic [TW-1:0]          chosen_q        [MAX_COURSES];
	logic [BW-1:0]          load_q          [MAX_TEACHERS];

	logic [KW1-1:0] level_q;
	logic [TW1-1:0] teacher_q;
	logic [TW1-1:0] sweep_q;
	logic [BW-1:0]  best_q;
	logic [BW-1:0]  top_q;
	logic           out_valid_q;
	logic           found_q;
	logic [LOAD_W-1:0] best_out_q;

	logic [TIW-1:0] t_ext;
	logic [CIW-1:0] c_ext, d_ext;
	logic           t_ok, c_ok, d_ok;
	logic [CW-1:0]  kidx, kpidx;
	logic [TW-1:0]  vidx, sidx, back_t;
	logic [KW1-1:0] level_prev;
	logic [MAX_COURSES-1:0] blocked_vec;
	logic [BW-1:0]  load_next;
	logic [XW-1:0]  best_x;

	assign t_ext = TIW'(teacher_index);
	assign c_ext = CIW'(course_index);
	assign d_ext = CIW'(other_course);
	assign t_ok  = XW'(teacher_index) < XW'(MAX_TEACHERS);
	assign c_ok  = XW'(course_index) < XW'(MAX_COURSES);
	assign d_ok  = XW'(other_course) < XW'(MAX_COURSES);

	assign kidx       = CW'(level_q);
	assign level_prev = level_q - KW1'(1);
	assign kpidx      = CW'(level_prev);
	assign vidx       = teacher_q[TW-1:0];
	assign sidx       = sweep_q[TW-1:0];
	assign back_t     = chosen_q[kpidx];
	assign load_next  = load_q[vidx] + BW'(1);

	// The conflict relation is symmetric, so row k holds the column of course k.
	always_comb begin
		for (int i = 0; i < MAX_COURSES; i++) begin
			blocked_vec[i] = (chosen_q[i] == vidx) && conflict_rows_q[kidx][i]
				&& (XW'(i) < XW'(level_q));
		end
	end

	assign stat.level_full    = XW'(level_q) >= XW'(num_courses);
	assign stat.teachers_done = XW'(teacher_q) >= XW'(num_teachers);
	assign stat.may_take      = teach_rows_q[vidx][kidx] && !(|blocked_vec);
	assign stat.fits          = load_next < best_q;
	assign stat.level_zero    = (level_q == '0);
	assign stat.sweep_done    = XW'(sweep_q) >= XW'(num_teachers);
	assign stat.out_free      = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TEACHERS; i++) begin
				teach_rows_q[i] <= '0;
				load_q[i]       <= '0;
			end
			for (int i = 0; i < MAX_COURSES; i++) begin
				conflict_rows_q[i] <= '0;
			end
			level_q     <= '0;
			teacher_q   <= '0;
			sweep_q     <= '0;
			best_q      <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_teach && t_ok && c_ok) begin
				teach_rows_q[t_ext[TW-1:0]][c_ext[CW-1:0]] <= 1'b1;
			end
			if (cmd.load_conflict && c_ok && d_ok) begin
				conflict_rows_q[c_ext[CW-1:0]][d_ext[CW-1:0]] <= 1'b1;
				if (c_ext != d_ext) begin
					conflict_rows_q[d_ext[CW-1:0]][c_ext[CW-1:0]] <= 1'b1;
				end
			end
			if (cmd.init) begin
				level_q   <= '0;
				teacher_q <= '0;
				best_q    <= BW'(XW'(num_courses) + XW'(1));
			end
			if (cmd.take_deeper) begin
				load_q[vidx] <= load_next;
				level_q      <= level_q + KW1'(1);
				teacher_q    <= '0;
			end
			if (cmd.skip_teacher) begin
				teacher_q <= teacher_q + TW1'(1);
			end
			if (cmd.back) begin
				load_q[back_t] <= load_q[back_t] - BW'(1);
				level_q        <= level_prev;
				teacher_q      <= TW1'(back_t) + TW1'(1);
			end
			if (cmd.sweep_clr) begin
				sweep_q <= '0;
				top_q   <= '0;
			end
			if (cmd.sweep_step) begin
				if (load_q[sidx] > top_q) top_q <= load_q[sidx];
				sweep_q <= sweep_q + TW1'(1);
			end
			if (cmd.sweep_commit && top_q < best_q) begin
				best_q <= top_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The search reads only levels it wrote earlier, so this store needs no reset.
	always_ff @(posedge clk) begin
		if (cmd.take_deeper) begin
			chosen_q[kidx] <= vidx;
		end
	end

	assign best_x = XW'(best_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			found_q <= best_x <= XW'(num_courses);
			if (best_x > XW'(num_courses)) begin
				best_out_q <= '0;
			end else if (best_x > XW'(63)) begin
				best_out_q <= LOAD_W'(63);
			end else begin
				best_out_q <= LOAD_W'(best_x);
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign best_max_load = best_out_q;

endmodule

@@ rtl/min_max_load_assignment_search_unit.sv @@
`timescale 1ns / 1ps
// Balanced teacher assignment search.
// The slave stream carries load and solve items; tdata holds op, teacher_index,
// course_index and other_course. A teach-bit or conflict-pair item is taken and
// returns nothing. A solve item starts an exhaustive depth-first
// branch-and-bound search and returns one item on the master stream: found in
// bit 0 and best_max_load above it.
// Each search step tries one candidate teacher at the current course or undoes
// one level; a complete assignment adds a max-load scan of num_teachers loads.
// Search length is data dependent and tready on the slave side stays low until
// the result is registered. The result waits in an output register; while it
// is not taken, load items are still accepted and a further solve runs but
// holds its result back. Reset clears the teach and conflict stores, the loads
// and any pending result, and sets num_teachers to 16 and num_courses to 32
// (saturated). The user writes configuration through the APB port only while
// the block is idle; the block itself does not enforce this.
module min_max_load_assignment_search_unit #(
	parameter int MAX_TEACHERS = mmlas_pkg::DEF_MAX_TEACHERS,
	parameter int MAX_COURSES  = mmlas_pkg::DEF_MAX_COURSES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// op[1:0], teacher_index[5:2], course_index[10:6], other_course[15:11]
	input  logic [mmlas_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// found[0], best_max_load[6:1], zero[7]
	output logic [mmlas_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mmlas_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import mmlas_pkg::*;

	localparam int XW = 8;
	localparam int NT_RST = (MAX_TEACHERS < 16) ? MAX_TEACHERS : 16;
	localparam int NC_RST = (MAX_COURSES < 32) ? MAX_COURSES : 32;

	logic [NT_W-1:0] num_teachers_q;
	logic [NC_W-1:0] num_courses_q;
	logic            cfg_write;
	mmlas_cmd_t      cmd;
	mmlas_stat_t     stat;
	logic            found;
	logic [LOAD_W-1:0] best_max_load;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_teachers_q <= NT_W'(NT_RST);
			num_courses_q  <= NC_W'(NC_RST);
		end else if (cfg_write) begin
			case (paddr)
				REG_NUM_TEACHERS: begin
					num_teachers_q <= (XW'(pwdata[NT_W-1:0]) > XW'(MAX_TEACHERS))
						? NT_W'(MAX_TEACHERS) : pwdata[NT_W-1:0];
				end
				REG_NUM_COURSES: begin
					num_courses_q <= (XW'(pwdata[NC_W-1:0]) > XW'(MAX_COURSES))
						? NC_W'(MAX_COURSES) : pwdata[NC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr)
			REG_NUM_TEACHERS: prdata = 32'(num_teachers_q);
			REG_NUM_COURSES:  prdata = 32'(num_courses_q);
			default:          prdata = '0;
		endcase
	end

	mmlas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tdata[1:0]),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mmlas_dp #(
		.MAX_TEACHERS (MAX_TEACHERS),
		.MAX_COURSES  (MAX_COURSES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.teacher_index (s_tdata[5:2]),
		.course_index  (s_tdata[10:6]),
		.other_course  (s_tdata[15:11]),
		.num_teachers  (num_teachers_q),
		.num_courses   (num_courses_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.found         (found),
		.best_max_load (best_max_load)
	);

	assign m_tdata = {1'b0, best_max_load, found};

	// A new result never overwrites one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("result overwritten while pending");

	// The slave side is never ready while a search is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_deeper || cmd.skip_teacher || cmd.sweep_step) |-> !s_tready)
		else $error("input accepted during search");

	// A not-found result carries a zero load.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[6:1] == '0))
		else $error("nonzero load on not-found result");

endmodule

@@ test/tb_min_max_load_assignment_search_unit.sv @@
`timescale 1ns / 1ps
module tb_min_max_load_assignment_search_unit;
	import mmlas_pkg::*;

	localparam int LIMIT_CYCLES = 20000000;
	localparam int NPH = 12;

	typedef struct packed {
		logic [CIDX_W-1:0] other_course;
		logic [CIDX_W-1:0] course_index;
		logic [TIDX_W-1:0] teacher_index;
		op_t op;
	} load_item_t;

	typedef struct {
		logic found;
		logic [LOAD_W-1:0] best;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	min_max_load_assignment_search_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Predictor state.
	logic [31:0] teach_sets [16];
	logic [31:0] conflict_sets [32];
	int teachers_used = 16;
	int courses_used = 32;

	load_item_t pending_items[$];
	answer_t answers_due[$];
	int mismatches = 0;
	int answers_seen = 0;
	int searches_sent = 0;
	int sender_gap = 0;
	int receiver_gap = 0;
	int long_holds_asked = 0;
	int long_holds_done = 0;
	int hold_left = 0;
	bit calm = 0;
	longint cycles = 0;

	function automatic answer_t search_min_max_load();
		int chosen [32];
		int next_try [33];
		int load [16];
		int k, v, t, top, best;
		bit done, back, ok;
		answer_t a;
		for (t = 0; t < 16; t++) load[t] = 0;
		best = courses_used + 1;
		k = 0;
		next_try[0] = 0;
		done = 0;
		while (!done) begin
			back = 0;
			if (k >= courses_used) begin
				top = 0;
				for (t = 0; t < teachers_used; t++)
					if (load[t] > top) top = load[t];
				if (top < best) best = top;
				back = 1;
			end else begin
				for (v = next_try[k]; v < teachers_used; v++) begin
					ok = teach_sets[v][k];
					for (int i = 0; i < k; i++)
						if (chosen[i] == v && conflict_sets[i][k]) ok = 0;
					if (ok) break;
				end
				if (v < teachers_used) begin
					chosen[k] = v;
					load[v]++;
					if (load[v] < best) begin
						k++;
						next_try[k] = 0;
					end else begin
						load[v]--;
						next_try[k] = v + 1;
					end
				end else begin
					back = 1;
				end
			end
			if (back) begin
				if (k == 0) begin
					done = 1;
				end else begin
					k--;
					load[chosen[k]]--;
					next_try[k] = chosen[k] + 1;
				end
			end
		end
		a.found = (best <= courses_used);
		a.best = a.found ? LOAD_W'(best) : '0;
		return a;
	endfunction

	function automatic void apply_item(load_item_t it);
		case (it.op)
			OP_SET_TEACH: teach_sets[it.teacher_index][it.course_index] = 1'b1;
			OP_SET_CONFLICT: begin
				conflict_sets[it.course_index][it.other_course] = 1'b1;
				conflict_sets[it.other_course][it.course_index] = 1'b1;
			end
			OP_SOLVE: begin
				answers_due.insert(answers_due.size(), search_min_max_load());
				searches_sent++;
			end
			default: ;
		endcase
	endfunction

	// Driver: one item offered at a time, held until accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !s_tready) begin
				// hold the current item
			end else begin
				if (s_tvalid) apply_item(load_item_t'(s_tdata));
				if (sender_gap > 0) begin
					sender_gap <= sender_gap - 1;
					s_tvalid <= 0;
				end else if (!calm && $urandom_range(0, 11) == 0) begin
					sender_gap <= $urandom_range(0, 15);
					s_tvalid <= 0;
				end else if (pending_items.size() > 0) begin
					s_tdata <= pending_items.pop_front();
					s_tvalid <= 1;
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// Monitor: checks each accepted answer and paces tready.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end else if (arst_n) begin
			if (m_tvalid && m_tready) begin
				answers_seen++;
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected answer %h", m_tdata);
				end else begin
					answer_t e;
					e = answers_due.pop_front();
					if (m_tdata[0] !== e.found || m_tdata[LOAD_W:1] !== e.best ||
							m_tdata[OUT_DATA_W-1] !== 1'b0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("answer %0d: expected found %0d load %0d, got %0d %0d",
								answers_seen, e.found, e.best, m_tdata[0],
								m_tdata[LOAD_W:1]);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 0;
			end else if (long_holds_done < long_holds_asked) begin
				long_holds_done <= long_holds_done + 1;
				hold_left <= 400;
				m_tready <= 0;
			end else if (receiver_gap > 0) begin
				receiver_gap <= receiver_gap - 1;
				m_tready <= 0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				receiver_gap <= $urandom_range(0, 15);
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	task automatic write_reg(reg_addr_t a, logic [31:0] d);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (a == REG_NUM_TEACHERS)
			teachers_used = (int'(d[4:0]) > 16) ? 16 : int'(d[4:0]);
		else
			courses_used = (int'(d[5:0]) > 32) ? 32 : int'(d[5:0]);
	endtask

	task automatic settle();
		while (pending_items.size() > 0 || s_tvalid || answers_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_sizes(int nt, int nc);
		settle();
		write_reg(REG_NUM_TEACHERS, nt);
		write_reg(REG_NUM_COURSES, nc);
	endtask

	task automatic push_item(op_t op, int t, int c, int d);
		load_item_t it;
		it.op = op;
		it.teacher_index = TIDX_W'(t);
		it.course_index = CIDX_W'(c);
		it.other_course = CIDX_W'(d);
		pending_items.insert(pending_items.size(), it);
	endtask

	// Sizes kept small enough that the exhaustive search stays short.
	int phase_nt [7] = '{1, 16, 2, 4, 3, 6, 5};
	int phase_nc [7] = '{1, 2, 6, 4, 6, 3, 4};

	initial begin
		int r;
		for (int i = 0; i < 16; i++) teach_sets[i] = '0;
		for (int i = 0; i < 32; i++) conflict_sets[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// Empty stores: all but the zero-course search fail at course 0.
		push_item(OP_SOLVE, 0, 0, 0);
		set_sizes(31, 63);
		push_item(OP_SOLVE, 15, 31, 31);
		set_sizes(0, 5);
		push_item(OP_SOLVE, 0, 0, 0);
		set_sizes(16, 0);
		push_item(OP_SOLVE, 0, 0, 0);

		// Directed loads: self conflict, field extremes, unused op.
		set_sizes(3, 4);
		push_item(OP_SET_TEACH, 15, 31, 0);
		push_item(OP_SET_CONFLICT, 0, 31, 0);
		push_item(OP_SET_CONFLICT, 0, 2, 2);
		push_item(OP_UNUSED, 15, 31, 31);
		push_item(OP_SET_TEACH, 0, 0, 0);
		push_item(OP_SET_TEACH, 0, 1, 0);
		push_item(OP_SOLVE, 0, 0, 0);
		push_item(OP_SET_TEACH, 1, 1, 0);
		push_item(OP_SET_TEACH, 0, 2, 0);
		push_item(OP_SET_TEACH, 2, 3, 0);
		push_item(OP_SOLVE, 0, 0, 0);
		push_item(OP_SET_CONFLICT, 0, 0, 2);
		push_item(OP_SET_TEACH, 1, 2, 0);
		push_item(OP_SET_TEACH, 0, 3, 0);
		push_item(OP_SOLVE, 0, 0, 0);

		for (int p = 0; p < NPH; p++) begin
			set_sizes(phase_nt[p % 7], phase_nc[p % 7]);
			if (p >= NPH - 2) calm = 1;
			if (p == 3) begin
				long_holds_asked++;
				for (int i = 0; i < 12; i++) push_item(OP_SOLVE, 0, 0, 0);
			end
			for (int i = 0; i < 110; i++) begin
				int t, c, d;
				r = $urandom_range(0, 99);
				t = $urandom_range(0, 3) != 0 ? $urandom_range(0, teachers_used - 1)
					: $urandom_range(0, 15);
				c = $urandom_range(0, 3) != 0 ? $urandom_range(0, courses_used - 1)
					: $urandom_range(0, 31);
				d = $urandom_range(0, 3) != 0 ? $urandom_range(0, courses_used - 1)
					: $urandom_range(0, 31);
				if (r < 50) push_item(OP_SET_TEACH, t, c, $urandom_range(0, 31));
				else if (r < 78) push_item(OP_SET_CONFLICT, $urandom_range(0, 15), c, d);
				else if (r < 93) push_item(OP_SOLVE, $urandom_range(0, 15),
					$urandom_range(0, 31), $urandom_range(0, 31));
				else push_item(OP_UNUSED, t, c, d);
			end
		end

		settle();
		repeat (50) @(posedge clk);
		if (answers_due.size() > 0) mismatches += answers_due.size();
		$display("Ran %0d searches over seven size settings plus saturated and empty sizes,",
			searches_sent);
		$display("with random stalls on both streams and a long output hold.");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
